[hw/rtl/pose_frame_converter_defines.svh]
// ---------------------------------------------------------------------------
// Pose frame converter assertion macros
// Shared concurrent assertion forms for the pose frame converter.
// ---------------------------------------------------------------------------
`ifndef POSE_FRAME_CONVERTER_DEFINES_SVH
`define POSE_FRAME_CONVERTER_DEFINES_SVH

// checked outside reset
`define PFC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked in every cycle, reset included
`define PFC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/pfc_pkg.sv]
// ---------------------------------------------------------------------------
// Pose frame converter package
// Fixed-point constants, arctangent table and stage types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfc_pkg;

   localparam int CORDIC_STAGES = 16;

   localparam int ADDR_W  = 3;
   localparam int IDX_BIT = 2;

   localparam logic REG_NET_X = 1'b0;
   localparam logic REG_NET_Y = 1'b1;

   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_REVERSE = 1'b1;

   localparam int TURN_Q16    = 411775;
   localparam int PI_Q16      = 205887;
   localparam int HALF_PI_Q16 = 102944;
   localparam int DEG90       = 23040;
   localparam int DEG360      = 92160;

   localparam logic signed [30:0] RAD2DEG_Q32 = 31'sd961263669;
   localparam logic [34:0]        DEG2RAD_Q32 = 35'd19190098069;
   localparam logic signed [33:0] KINV_Q30    = 34'sd652032874;

   // floor reciprocals for the turn reductions
   localparam int          RECIP_SHIFT = 40;
   localparam logic [23:0] RECIP_DEG   = 24'((64'd1 << RECIP_SHIFT) / DEG360);
   localparam logic [23:0] RECIP_TURN  = 24'((64'd1 << RECIP_SHIFT) / TURN_Q16);
   localparam int          DEG_BIAS    = 46 * DEG360;
   localparam int          TURN_BIAS   = 11 * TURN_Q16;

   localparam int XY_W   = 34;
   localparam int Z_W    = 32;
   localparam int BASE_W = 33;
   localparam int OFF_W  = 18;
   localparam int ANG_W  = 19;

   typedef struct packed {
      logic                     op;
      logic                     neg;
      logic [ANG_W-1:0]         ang;
      logic signed [BASE_W-1:0] bx;
      logic signed [BASE_W-1:0] by;
      logic signed [OFF_W-1:0]  off2;
   } side_type;

   typedef struct packed {
      logic                   valid;
      side_type               side;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } rot_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [ANG_W-1:0]   out_angle;
      logic               saturated;
   } result_type;

   function automatic logic signed [Z_W-1:0] atan_q28(input logic [4:0] k);
      logic signed [Z_W-1:0] v;
      case (k)
         5'd0:    v = 32'sd210828714;
         5'd1:    v = 32'sd124459458;
         5'd2:    v = 32'sd65760959;
         5'd3:    v = 32'sd33381290;
         5'd4:    v = 32'sd16755422;
         5'd5:    v = 32'sd8385879;
         5'd6:    v = 32'sd4193963;
         5'd7:    v = 32'sd2097109;
         5'd8:    v = 32'sd1048571;
         5'd9:    v = 32'sd524287;
         5'd10:   v = 32'sd262144;
         5'd11:   v = 32'sd131072;
         5'd12:   v = 32'sd65536;
         5'd13:   v = 32'sd32768;
         5'd14:   v = 32'sd16384;
         5'd15:   v = 32'sd8192;
         5'd16:   v = 32'sd4096;
         5'd17:   v = 32'sd2048;
         5'd18:   v = 32'sd1024;
         5'd19:   v = 32'sd512;
         5'd20:   v = 32'sd256;
         5'd21:   v = 32'sd128;
         5'd22:   v = 32'sd64;
         5'd23:   v = 32'sd32;
         5'd24:   v = 32'sd16;
         5'd25:   v = 32'sd8;
         5'd26:   v = 32'sd4;
         5'd27:   v = 32'sd2;
         5'd28:   v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/pfc_if.sv]
// ---------------------------------------------------------------------------
// Pose frame converter channels
// Valid/ready channels for pose requests and converted pose responses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfc_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [22:0] angle_in;
   logic signed [15:0] box_center_x;
   logic [15:0]        box_length;

   modport source (output valid, operation, pos_x, pos_y, angle_in, box_center_x,
                   box_length, input ready);
   modport sink (input valid, operation, pos_x, pos_y, angle_in, box_center_x,
                 box_length, output ready);
endinterface

interface pfc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic [18:0]        out_angle;
   logic               saturated;

   modport source (output valid, out_x, out_y, out_angle, saturated, input ready);
   modport sink (input valid, out_x, out_y, out_angle, saturated, output ready);
endinterface

[hw/rtl/pfc_csr.sv]
// ---------------------------------------------------------------------------
// Pose frame converter registers
// APB-style access to the network frame offsets.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [pfc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output logic signed [31:0]         net_x,
   output logic signed [31:0]         net_y
);
   import pfc_pkg::*;

   logic signed [31:0] net_x_ff, net_x_in;
   logic signed [31:0] net_y_ff, net_y_in;

   always_comb begin
      net_x_in = net_x_ff;
      net_y_in = net_y_ff;
      if (psel && penable && pwrite) begin
         case (paddr[IDX_BIT])
            REG_NET_X: net_x_in = signed'(pwdata);
            REG_NET_Y: net_y_in = signed'(pwdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         net_x_ff <= '0;
         net_y_ff <= '0;
      end else begin
         net_x_ff <= net_x_in;
         net_y_ff <= net_y_in;
      end
   end

   assign prdata = (paddr[IDX_BIT] == REG_NET_Y) ? unsigned'(net_y_ff) : unsigned'(net_x_ff);
   assign pready = 1'b1;
   assign net_x  = net_x_ff;
   assign net_y  = net_y_ff;

endmodule

[hw/rtl/pfc_angle.sv]
// ---------------------------------------------------------------------------
// Pose frame converter angle front end
// Six stages: unit scaling, turn reduction, heading fold, CORDIC seed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_angle (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic                 operation,
   input  logic signed [31:0]   pos_x,
   input  logic signed [31:0]   pos_y,
   input  logic signed [22:0]   angle_in,
   input  logic signed [15:0]   box_center_x,
   input  logic [15:0]          box_length,
   input  logic signed [31:0]   net_x,
   input  logic signed [31:0]   net_y,
   output pfc_pkg::rot_type     rot
);
   import pfc_pkg::*;

   localparam logic signed [19:0] T_TURN = 20'(TURN_Q16);
   localparam logic signed [19:0] T_PI   = 20'(PI_Q16);
   localparam logic signed [19:0] T_HALF = 20'(HALF_PI_Q16);

   logic [6:1] v_ff;

   // stage 1: degree product, base position, front offset
   side_type           s1_side_ff, s1_side_in;
   logic signed [22:0] s1_a_ff;
   logic signed [53:0] s1_prod_ff, s1_prod_in;

   // stage 2: biased values to reduce
   side_type    s2_side_ff;
   logic [23:0] s2_u1_ff, s2_u1_in;
   logic [23:0] s2_u2_ff, s2_u2_in;

   // stage 3: quotients
   side_type    s3_side_ff;
   logic [23:0] s3_u1_ff, s3_u2_ff;
   logic [6:0]  s3_q1_ff, s3_q1_in;
   logic [4:0]  s3_q2_ff, s3_q2_in;

   // stage 4: remainders
   side_type    s4_side_ff;
   logic [16:0] s4_r1_ff, s4_r1_in;
   logic [18:0] s4_r2_ff, s4_r2_in;

   // stage 5: radian product for the reverse path
   side_type    s5_side_ff;
   logic [16:0] s5_r1_ff;
   logic [18:0] s5_r2_ff;
   logic [51:0] s5_p2_ff, s5_p2_in;

   // stage 6: folded CORDIC angle
   rot_type     s6_ff, s6_in;

   logic signed [53:0] deg_sum;
   logic signed [21:0] deg;
   logic signed [24:0] v1;
   logic [47:0]        qp1, qp2;
   logic [24:0]        t1, t2;
   logic [51:0]        h_sum;
   logic [18:0]        h1, heading;
   logic signed [19:0] t;
   logic               neg;

   always_comb begin
      s1_side_in      = '0;
      s1_side_in.op   = operation;
      if (operation == OP_FORWARD) begin
         s1_side_in.bx = 33'(pos_x) + 33'(net_x);
         s1_side_in.by = 33'(pos_y) + 33'(net_y);
      end else begin
         s1_side_in.bx = 33'(pos_x) - 33'(net_x);
         s1_side_in.by = 33'(pos_y) - 33'(net_y);
      end
      s1_side_in.off2 = (18'(box_center_x) <<< 1) + 18'(signed'({1'b0, box_length}));
      s1_prod_in      = 54'(angle_in) * 54'(RAD2DEG_Q32);
   end

   always_comb begin
      deg_sum = s1_prod_ff + (54'sd1 <<< 31);
      deg     = 22'(deg_sum >>> 32);
      if (s1_side_ff.op == OP_FORWARD) v1 = 25'(DEG90) - 25'(deg);
      else                             v1 = 25'(DEG90) - 25'(s1_a_ff);
      s2_u1_in = 24'(v1 + 25'(DEG_BIAS));
      s2_u2_in = 24'(25'(s1_a_ff) + 25'(TURN_BIAS));
   end

   always_comb begin
      qp1      = 48'(s2_u1_ff) * 48'(RECIP_DEG);
      qp2      = 48'(s2_u2_ff) * 48'(RECIP_TURN);
      s3_q1_in = qp1[RECIP_SHIFT +: 7];
      s3_q2_in = qp2[RECIP_SHIFT +: 5];
   end

   // floor reciprocal: quotient is exact or one low
   always_comb begin
      t1 = 25'(s3_u1_ff) - 25'(s3_q1_ff) * 25'(DEG360);
      t2 = 25'(s3_u2_ff) - 25'(s3_q2_ff) * 25'(TURN_Q16);
      if (t1 >= 25'(DEG360))   t1 = t1 - 25'(DEG360);
      if (t2 >= 25'(TURN_Q16)) t2 = t2 - 25'(TURN_Q16);
      s4_r1_in = 17'(t1);
      s4_r2_in = 19'(t2);
   end

   assign s5_p2_in = 52'(s4_r1_ff) * 52'(DEG2RAD_Q32);

   always_comb begin
      h_sum = s5_p2_ff + (52'd1 << 31);
      h1    = 19'(h_sum >> 32);
      if (s5_side_ff.op == OP_REVERSE) heading = h1;
      else                             heading = s5_r2_ff;
      t   = 20'(signed'({1'b0, heading}));
      neg = 1'b0;
      if (t > T_PI) t = t - T_TURN;
      if (t > T_HALF) begin
         t   = t - T_PI;
         neg = 1'b1;
      end else if (t < -T_HALF) begin
         t   = t + T_PI;
         neg = 1'b1;
      end
      s6_in          = '0;
      s6_in.side     = s5_side_ff;
      s6_in.side.neg = neg;
      s6_in.side.ang = (s5_side_ff.op == OP_REVERSE) ? h1 : 19'(s5_r1_ff);
      s6_in.x        = KINV_Q30;
      s6_in.y        = '0;
      s6_in.z        = 32'(t) <<< 12;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s1_a_ff    <= angle_in;
         s1_prod_ff <= s1_prod_in;
         s2_side_ff <= s1_side_ff;
         s2_u1_ff   <= s2_u1_in;
         s2_u2_ff   <= s2_u2_in;
         s3_side_ff <= s2_side_ff;
         s3_u1_ff   <= s2_u1_ff;
         s3_u2_ff   <= s2_u2_ff;
         s3_q1_ff   <= s3_q1_in;
         s3_q2_ff   <= s3_q2_in;
         s4_side_ff <= s3_side_ff;
         s4_r1_ff   <= s4_r1_in;
         s4_r2_ff   <= s4_r2_in;
         s5_side_ff <= s4_side_ff;
         s5_r1_ff   <= s4_r1_ff;
         s5_r2_ff   <= s4_r2_ff;
         s5_p2_ff   <= s5_p2_in;
         s6_ff      <= s6_in;
      end
   end

   always_comb begin
      rot       = s6_ff;
      rot.valid = v_ff[6];
   end

endmodule

[hw/rtl/pfc_rot_stage.sv]
// ---------------------------------------------------------------------------
// Pose frame converter CORDIC stage
// One registered rotation-mode micro-rotation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_rot_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic [4:0]       shift,
   input  pfc_pkg::rot_type rot_i,
   output pfc_pkg::rot_type rot_o
);
   import pfc_pkg::*;

   logic                   valid_ff;
   rot_type                data_ff, data_in;
   logic signed [XY_W-1:0] x, y, xs, ys;
   logic signed [Z_W-1:0]  z, at;

   always_comb begin
      x  = rot_i.x;
      y  = rot_i.y;
      z  = rot_i.z;
      xs = x >>> shift;
      ys = y >>> shift;
      at = atan_q28(shift);
      data_in = rot_i;
      if (!z[Z_W-1]) begin
         data_in.x = x - ys;
         data_in.y = y + xs;
         data_in.z = z - at;
      end else begin
         data_in.x = x + ys;
         data_in.y = y - xs;
         data_in.z = z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    valid_ff <= 1'b0;
      else if (adv) valid_ff <= rot_i.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

   always_comb begin
      rot_o       = data_ff;
      rot_o.valid = valid_ff;
   end

endmodule

[hw/rtl/pfc_place.sv]
// ---------------------------------------------------------------------------
// Pose frame converter placement
// Sign fix, displacement multiply, position sum and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_place (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  pfc_pkg::rot_type    rot_i,
   output logic                res_valid,
   output pfc_pkg::result_type res
);
   import pfc_pkg::*;

   localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
   localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

   logic [3:1] v_ff;

   side_type               o1_side_ff;
   logic signed [XY_W-1:0] o1_c_ff, o1_c_in, o1_s_ff, o1_s_in;
   side_type               o2_side_ff;
   logic signed [51:0]     o2_dx_ff, o2_dx_in, o2_dy_ff, o2_dy_in;
   result_type             o3_ff, o3_in;

   logic signed [51:0]     sx, sy;
   logic signed [33:0]     dx, dy, rx, ry;

   always_comb begin
      o1_c_in = rot_i.side.neg ? -rot_i.x : rot_i.x;
      o1_s_in = rot_i.side.neg ? -rot_i.y : rot_i.y;
   end

   assign o2_dx_in = 52'(o1_side_ff.off2) * 52'(o1_c_ff);
   assign o2_dy_in = 52'(o1_side_ff.off2) * 52'(o1_s_ff);

   always_comb begin
      sx = o2_dx_ff + (52'sd1 <<< 30);
      sy = o2_dy_ff + (52'sd1 <<< 30);
      dx = 34'(sx >>> 31);
      dy = 34'(sy >>> 31);
      if (o2_side_ff.op == OP_FORWARD) begin
         rx = 34'(o2_side_ff.bx) + dx;
         ry = 34'(o2_side_ff.by) + dy;
      end else begin
         rx = 34'(o2_side_ff.bx) - dx;
         ry = 34'(o2_side_ff.by) - dy;
      end
      o3_in           = '0;
      o3_in.out_angle = o2_side_ff.ang;
      if (rx > POS_MAX) begin
         o3_in.out_x = 32'sh7FFFFFFF;  o3_in.saturated = 1'b1;
      end else if (rx < POS_MIN) begin
         o3_in.out_x = 32'sh80000000;  o3_in.saturated = 1'b1;
      end else begin
         o3_in.out_x = 32'(rx);
      end
      if (ry > POS_MAX) begin
         o3_in.out_y = 32'sh7FFFFFFF;  o3_in.saturated = 1'b1;
      end else if (ry < POS_MIN) begin
         o3_in.out_y = 32'sh80000000;  o3_in.saturated = 1'b1;
      end else begin
         o3_in.out_y = 32'(ry);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    v_ff <= '0;
      else if (adv) v_ff <= {v_ff[2:1], rot_i.valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o1_side_ff <= rot_i.side;
         o1_c_ff    <= o1_c_in;
         o1_s_ff    <= o1_s_in;
         o2_side_ff <= o1_side_ff;
         o2_dx_ff   <= o2_dx_in;
         o2_dy_ff   <= o2_dy_in;
         o3_ff      <= o3_in;
      end
   end

   assign res_valid = v_ff[3];
   assign res       = o3_ff;

endmodule

[hw/rtl/pose_frame_converter.sv]
// ---------------------------------------------------------------------------
// Pose frame converter
// Moves a vehicle pose between reference-point and front-bumper frames.
// ---------------------------------------------------------------------------
// Usage:
//  - req carries one pose word: operation (0 forward, 1 reverse), position,
//    angle and bounding box; a word is taken when req.valid and req.ready.
//  - rsp returns one converted word per request, in request order.
//  - psel/penable/pwrite write net_offset_x at byte 0 and net_offset_y at
//    byte 4; write them only while no pose is in flight.
//  - Throughput: one pose per cycle while the skid buffer is not full.
//    The path is fully pipelined: six angle stages (scaling, two-step
//    reciprocal turn reduction, fold), CORDIC_STAGES rotation stages,
//    three placement stages and the output register.
//  - Reset clears all valid bits and both offsets; no clearing pass.
//  - Receiver stall: the output register holds its word and a one-word
//    skid buffer catches the next; req.ready drops only while the skid
//    buffer is full, and then the whole pipeline holds in place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pose_frame_converter_defines.svh"

module pose_frame_converter (
   input  logic                       clock,
   input  logic                       reset,
   pfc_req_if.sink                    req,
   pfc_rsp_if.source                  rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [pfc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import pfc_pkg::*;

   logic signed [31:0] net_x, net_y;
   logic               adv;
   rot_type            chain [0:CORDIC_STAGES];
   logic               res_valid;
   result_type         res;

   // output register plus skid word
   result_type out_ff, out_in, skid_ff, skid_in;
   logic       out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic       take;

   pfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .net_x   (net_x),
      .net_y   (net_y)
   );

   // whole pipeline moves together; it holds only while the skid is full
   assign adv       = !skid_v_ff;
   assign req.ready = adv;

   pfc_angle u_angle (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req.valid),
      .operation    (req.operation),
      .pos_x        (req.pos_x),
      .pos_y        (req.pos_y),
      .angle_in     (req.angle_in),
      .box_center_x (req.box_center_x),
      .box_length   (req.box_length),
      .net_x        (net_x),
      .net_y        (net_y),
      .rot          (chain[0])
   );

   // shift index wraps at 32 like the arctangent table
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      pfc_rot_stage u_stage (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .shift (5'(i)),
         .rot_i (chain[i]),
         .rot_o (chain[i+1])
      );
   end

   pfc_place u_place (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .rot_i     (chain[CORDIC_STAGES]),
      .res_valid (res_valid),
      .res       (res)
   );

   assign take = out_v_ff && rsp.ready;

   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         // pipeline frozen; drain skid into the output register
         if (take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || take) begin
         out_in   = res;
         out_v_in = res_valid;
      end else if (res_valid) begin
         skid_in   = res;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.out_x     = out_ff.out_x;
   assign rsp.out_y     = out_ff.out_y;
   assign rsp.out_angle = out_ff.out_angle;
   assign rsp.saturated = out_ff.saturated;

   `PFC_ASSERT(a_skid_behind_out, skid_v_ff |-> out_v_ff, "skid word without output word")
   `PFC_ASSERT(a_stall_cause, !req.ready |-> $past(rsp.valid && !rsp.ready), "stall w/o held word")
   `PFC_ASSERT_RST(a_reset_empty, reset |=> (!rsp.valid && req.ready), "busy after reset")

endmodule
